// ----- rtl/small_fast_prng_ranged_draw_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the ranged draw unit.
// ----------------------------------------------------------------------------
`ifndef SMALL_FAST_PRNG_RANGED_DRAW_UNIT_ASSERT_SVH
`define SMALL_FAST_PRNG_RANGED_DRAW_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SFPRD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFPRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sfprd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfprd_pkg
// Types, constants and helpers shared by the ranged draw unit.
// ----------------------------------------------------------------------------
package sfprd_pkg;

   localparam int unsigned DataWidth        = 64;
   localparam int unsigned MixRoundsDefault = 20;
   localparam int unsigned RotB             = 27;
   localparam int unsigned RotC             = 17;

   typedef logic [DataWidth-1:0] word_type;

   localparam word_type StartWordA = 64'h0000_0000_f1ea_5eed;

   // Request action codes.
   localparam logic ActionRestart = 1'b0;
   localparam logic ActionDraw    = 1'b1;

   // Control from the sequencer to the mixing datapath.
   typedef struct packed {
      logic load;
      logic step;
   } mix_ctl_type;

   // Status from the remainder unit.
   typedef struct packed {
      logic busy;
      logic done;
   } rem_sts_type;

   // Rotate left by a constant amount between 1 and DataWidth-1.
   function automatic word_type rotl_word(input word_type v, input int unsigned k);
      return (v << k) | (v >> (DataWidth - k));
   endfunction

endpackage

// ----- rtl/sfprd_req_if.sv -----
// ----------------------------------------------------------------------------
// sfprd_req_if
// Request channel: action and the inclusive bounds of a draw.
// ----------------------------------------------------------------------------
interface sfprd_req_if;
   import sfprd_pkg::*;

   logic     valid;
   logic     ready;
   logic     action;
   word_type low_bound;
   word_type high_bound;

   modport source (output valid, output action, output low_bound, output high_bound,
                   input ready);
   modport sink   (input valid, input action, input low_bound, input high_bound,
                   output ready);
endinterface

// ----- rtl/sfprd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sfprd_rsp_if
// Response channel: the drawn value.
// ----------------------------------------------------------------------------
interface sfprd_rsp_if;
   import sfprd_pkg::*;

   logic     valid;
   logic     ready;
   word_type value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/small_fast_prng_ranged_draw_unit.sv -----
// ----------------------------------------------------------------------------
// small_fast_prng_ranged_draw_unit - ranged draws from a four-word generator.
// Draw: two half rounds, 64 remainder steps, select and output; an empty,
// single or full range skips the remainder loop.
// Restart: the mixing rounds on the shared mixing datapath, no response.
// Reset runs that restart with seed zero, so the request side is not ready for it.
// ----------------------------------------------------------------------------
`include "small_fast_prng_ranged_draw_unit_assert.svh"

module small_fast_prng_ranged_draw_unit #(
   parameter int unsigned MIX_ROUNDS = sfprd_pkg::MixRoundsDefault
) (
   input  logic                clock,
   input  logic                reset,
   sfprd_req_if.sink           req,
   sfprd_rsp_if.source         rsp,
   input  logic                csr_write_enable,
   input  sfprd_pkg::word_type csr_write_data
);
   import sfprd_pkg::*;

   // Sequencer states. The block only takes a request while idle.
   localparam logic [2:0] StIdle = 3'd0;  // waiting for a request
   localparam logic [2:0] StMix  = 3'd1;  // restart rounds after a load
   localparam logic [2:0] StAdv  = 3'd2;  // one generator advance for a draw
   localparam logic [2:0] StSel  = 3'd3;  // raw output ready: divide or not
   localparam logic [2:0] StDiv  = 3'd4;  // remainder unit running
   localparam logic [2:0] StDone = 3'd5;  // load the response register

   localparam int unsigned RoundWidth = $clog2(MIX_ROUNDS + 2);

   logic [2:0]            state_ff, state_in;
   logic [RoundWidth-1:0] rounds_ff, rounds_in;
   word_type              seed_ff;
   word_type              lo_ff, lo_in;
   word_type              diff_ff, diff_in;
   logic                  single_ff, single_in;
   logic                  full_ff, full_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              value_ff, value_in;

   logic                  accept;
   logic [DataWidth:0]    span;
   mix_ctl_type           mix_ctl;
   logic                  mix_phase;
   word_type              raw;
   logic                  rem_start;
   rem_sts_type           rem_sts;
   word_type              remainder;
   word_type              addend;
   logic                  rsp_load;

   // The seed register is written straight from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_write_enable) begin
         seed_ff <= csr_write_data;
      end
   end

   assign req.ready = (state_ff == StIdle);
   assign accept    = req.valid && req.ready;

   // One 65-bit subtract classifies the range. A borrow means low is above
   // high, and a zero difference means a single value; both return low as it
   // is. An all-ones difference is the full range, where the count wraps to
   // zero and the raw output is used without division.
   assign span = {1'b0, req.high_bound} - {1'b0, req.low_bound};

   // The response is low plus one of three addends.
   always_comb begin
      if (single_ff) begin
         addend = '0;
      end else if (full_ff) begin
         addend = raw;
      end else begin
         addend = remainder;
      end
   end

   always_comb begin
      state_in  = state_ff;
      rounds_in = rounds_ff;
      lo_in     = lo_ff;
      diff_in   = diff_ff;
      single_in = single_ff;
      full_in   = full_ff;
      mix_ctl   = '0;
      rem_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (req.action == ActionRestart) begin
                  // Load the words now and run the rounds in StMix.
                  mix_ctl.load = 1'b1;
                  rounds_in    = RoundWidth'(MIX_ROUNDS);
                  state_in     = StMix;
               end else begin
                  lo_in     = req.low_bound;
                  diff_in   = span[DataWidth-1:0];
                  single_in = span[DataWidth] || (span[DataWidth-1:0] == '0);
                  full_in   = !span[DataWidth] && (&span[DataWidth-1:0]);
                  state_in  = (span[DataWidth] || (span[DataWidth-1:0] == '0)) ?
                              StDone : StAdv;
               end
            end
         end
         StMix: begin
            // Each round takes two half steps on the mixing datapath.
            if (rounds_ff == '0) begin
               state_in = StIdle;
            end else begin
               mix_ctl.step = 1'b1;
               if (mix_phase) begin
                  rounds_in = rounds_ff - RoundWidth'(1);
               end
            end
         end
         StAdv: begin
            mix_ctl.step = 1'b1;
            if (mix_phase) begin
               state_in = StSel;
            end
         end
         StSel: begin
            if (full_ff) begin
               state_in = StDone;
            end else begin
               rem_start = 1'b1;
               state_in  = StDiv;
            end
         end
         StDiv: begin
            if (rem_sts.done) begin
               state_in = StDone;
            end
         end
         StDone: begin
            // Wait for the response register to be free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   assign value_in     = rsp_load ? (lo_ff + addend) : value_ff;

   // After reset the words hold the loaded start values and the sequencer
   // runs the restart rounds before it takes the first request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StMix;
         rounds_ff    <= RoundWidth'(MIX_ROUNDS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rounds_ff    <= rounds_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      diff_ff   <= diff_in;
      single_ff <= single_in;
      full_ff   <= full_in;
      value_ff  <= value_in;
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.value = value_ff;

   sfprd_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .mix_ctl (mix_ctl),
      .seed    (seed_ff),
      .phase   (mix_phase),
      .raw     (raw)
   );

   // The count is the difference plus one; it is never zero on this path.
   sfprd_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (raw),
      .divisor   (diff_ff + word_type'(1)),
      .sts       (rem_sts),
      .remainder (remainder)
   );

   `SFPRD_ASSERT_IMPLIES(a_ready_rem_idle, clock, reset, req.ready, !rem_sts.busy, "request taken while the remainder unit is busy")
   `SFPRD_ASSERT_NEXT(a_restart_mixes, clock, reset, accept && (req.action == ActionRestart), state_ff == StMix, "restart did not enter the mixing rounds")
   `SFPRD_ASSERT_IMPLIES(a_load_slot_free, clock, reset, rsp_load, !rsp_valid_ff || rsp.ready, "response overwritten before it was taken")
   `SFPRD_ASSERT_IMPLIES(a_div_unit_active, clock, reset, state_ff == StDiv, rem_sts.busy || rem_sts.done, "waiting on an idle remainder unit")

endmodule

// ----- rtl/sfprd_mix.sv -----
// ----------------------------------------------------------------------------
// sfprd_mix
// Generator words and the shared mixing datapath, one half round per step.
// ----------------------------------------------------------------------------
module sfprd_mix (
   input  logic                   clock,
   input  logic                   reset,
   input  sfprd_pkg::mix_ctl_type mix_ctl,
   input  sfprd_pkg::word_type    seed,
   output logic                   phase,
   output sfprd_pkg::word_type    raw
);
   import sfprd_pkg::*;

   word_type a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type a_in, b_in, c_in, d_in, e_in;
   logic     phase_ff, phase_in;

   // First half: e and the new a. Second half: b, c and d, each one add.
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      phase_in = phase_ff;
      if (mix_ctl.load) begin
         a_in     = StartWordA;
         b_in     = seed;
         c_in     = seed;
         d_in     = seed;
         phase_in = 1'b0;
      end else if (mix_ctl.step) begin
         if (!phase_ff) begin
            e_in     = a_ff - rotl_word(b_ff, RotB);
            a_in     = b_ff ^ rotl_word(c_ff, RotC);
            phase_in = 1'b1;
         end else begin
            b_in     = c_ff + d_ff;
            c_in     = d_ff + e_ff;
            d_in     = e_ff + a_ff;
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff     <= StartWordA;
         b_ff     <= '0;
         c_ff     <= '0;
         d_ff     <= '0;
         phase_ff <= 1'b0;
      end else begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      e_ff <= e_in;
   end

   assign phase = phase_ff;
   assign raw   = d_ff;

endmodule

// ----- rtl/sfprd_rem.sv -----
// ----------------------------------------------------------------------------
// sfprd_rem
// Bit-serial restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module sfprd_rem (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sfprd_pkg::word_type    dividend,
   input  sfprd_pkg::word_type    divisor,
   output sfprd_pkg::rem_sts_type sts,
   output sfprd_pkg::word_type    remainder
);
   import sfprd_pkg::*;

   localparam int unsigned CountWidth = $clog2(DataWidth + 1);

   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   word_type              rem_ff, rem_in;
   word_type              dvd_ff, dvd_in;
   word_type              dsr_ff, dsr_in;
   logic [DataWidth:0]    partial;
   logic [DataWidth:0]    trial;

   assign partial = {rem_ff, dvd_ff[DataWidth-1]};
   assign trial   = partial - {1'b0, dsr_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CountWidth'(DataWidth);
         rem_in = '0;
         dvd_in = dividend;
         dsr_in = divisor;
      end else if (cnt_ff != '0) begin
         // A clear borrow means the shifted remainder reached the divisor.
         rem_in  = trial[DataWidth] ? partial[DataWidth-1:0] : trial[DataWidth-1:0];
         dvd_in  = {dvd_ff[DataWidth-2:0], 1'b0};
         cnt_in  = cnt_ff - CountWidth'(1);
         done_in = (cnt_ff == CountWidth'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign sts.busy  = (cnt_ff != '0);
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- tb/sv/tb_small_fast_prng_ranged_draw_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_small_fast_prng_ranged_draw_unit
// Self-checking bench for the ranged draw unit. A scoreboard class keeps its
// own copy of the four generator words and the seed register, predicts the
// value of every draw request as it is accepted, and compares each response
// in order. Directed requests cover the range corner cases; then several
// phases, each under a different seed, send random restarts and draws while
// both channels stall at random, except in one phase with no gaps.
// ----------------------------------------------------------------------------
module tb_small_fast_prng_ranged_draw_unit;
   import sfprd_pkg::*;

   // Longest the unit may keep working after the last response: a restart
   // gives no response, so this leaves ample room.
   localparam int SETTLE_CYCLES = 200;
   // The slowest legal run is roughly 2100 requests, each costing block time plus
   // the longest gap on either side; this limit is several times that.
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 250;
   localparam word_type ALL_ONES = {DataWidth{1'b1}};

   // Scoreboard: a private model of the generator and the queue of values
   // that the accepted draw requests are owed.
   class draw_scoreboard;
      word_type seed_reg;
      word_type word_a, word_b, word_c, word_d;
      word_type owed_values[$];

      function new();
         seed_reg = '0;
         restart();
      endfunction

      function word_type spin_word(word_type v, int unsigned k);
         return (v << k) | (v >> (DataWidth - k));
      endfunction

      // One round of mixing; the new fourth word is the raw output.
      function word_type advance();
         word_type e;
         e      = word_a - spin_word(word_b, 27);
         word_a = word_b ^ spin_word(word_c, 17);
         word_b = word_c + word_d;
         word_c = word_d + e;
         word_d = e + word_a;
         return word_d;
      endfunction

      function void restart();
         word_a = StartWordA;
         word_b = seed_reg;
         word_c = seed_reg;
         word_d = seed_reg;
         for (int i = 0; i < MixRoundsDefault; i++) begin
            void'(advance());
         end
      endfunction

      function void note_request(logic action, word_type lo, word_type hi);
         word_type count;
         word_type raw;
         if (action == ActionRestart) begin
            restart();
         end else if (lo >= hi) begin
            owed_values.push_back(lo);
         end else begin
            count = (hi - lo) + word_type'(1);
            raw   = advance();
            if (count == '0) begin
               owed_values.push_back(lo + raw);
            end else begin
               owed_values.push_back(lo + raw % count);
            end
         end
      endfunction

      // Returns an empty string when the response matches, else a description.
      function string check_value(word_type got);
         word_type want;
         if (owed_values.size() == 0) begin
            return $sformatf("response %h arrived with nothing owed", got);
         end
         want = owed_values.pop_front();
         if (got !== want) begin
            return $sformatf("response value %h, expected %h", got, want);
         end
         return "";
      endfunction

      function int pending();
         return owed_values.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_write_enable;
   word_type csr_write_data;

   sfprd_req_if req_bus ();
   sfprd_rsp_if rsp_bus ();

   draw_scoreboard board;
   int error_count = 0;
   // While calm is set neither side inserts gaps, giving back-to-back traffic.
   bit calm = 1'b0;

   small_fast_prng_ranged_draw_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   function automatic word_type random_word();
      return {$urandom(), $urandom()};
   endfunction

   // Every task below is entered and left just after a rising edge, so all
   // drives land as nonblocking assignments in that time step.
   task automatic send_request(logic action, word_type lo, word_type hi);
      int gap;
      req_bus.valid      <= 1'b1;
      req_bus.action     <= action;
      req_bus.low_bound  <= lo;
      req_bus.high_bound <= hi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // The request was taken at this edge; predict its response now, in the
      // driver, so the scoreboard is never a step behind the stimulus.
      board.note_request(action, lo, hi);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic draw(word_type lo, word_type hi);
      send_request(ActionDraw, lo, hi);
   endtask

   // The sender stops until every owed response has come, then lets the unit
   // finish any restart that is still mixing.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called with the unit idle.
   task automatic write_seed(word_type value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.seed_reg = value;
   endtask

   // One random request. Most are draws of assorted range shapes; a few are
   // restarts with junk bounds, which the unit must ignore.
   task automatic random_request();
      word_type lo;
      word_type hi;
      word_type span;
      word_type tmp;
      int kind;
      lo = random_word();
      hi = random_word();
      if ($urandom_range(0, 99) < 6) begin
         send_request(ActionRestart, lo, hi);
      end else begin
         kind = $urandom_range(0, 9);
         case (kind)
            0: begin
               hi = lo;
            end
            1: begin
               if (lo < hi) begin
                  tmp = lo;
                  lo  = hi;
                  hi  = tmp;
               end
            end
            2: begin
               lo = '0;
               hi = ALL_ONES;
            end
            3, 4, 5: begin
               span = word_type'($urandom_range(1, 300));
               if (lo > ALL_ONES - span) begin
                  lo = ALL_ONES - span;
               end
               hi = lo + span;
            end
            6: begin
               span = (word_type'(1) << $urandom_range(1, 63)) - word_type'(1);
               lo   = lo % (ALL_ONES - span + word_type'(1));
               hi   = lo + span;
            end
            default: begin
               // Fully random bounds, either order.
            end
         endcase
         draw(lo, hi);
      end
   endtask

   // Response side: ready wanders high and low with the same gap profile.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Every response taken is checked against the oldest owed value.
   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         msg = board.check_value(rsp_bus.value);
         if (msg != "") begin
            report_mismatch(msg);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TIMEOUT after %0d cycles", CYCLE_LIMIT);
      $display("tb_small_fast_prng_ranged_draw_unit: errors");
      $finish;
   end

   initial begin
      word_type seed_value;
      board = new();
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.action     <= ActionDraw;
      req_bus.low_bound  <= '0;
      req_bus.high_bound <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset seed of zero. The unit is busy
      // mixing for a while after reset; the handshake simply waits for it.
      draw('0, ALL_ONES);                     // full range: the count wraps to zero
      draw('0, '0);                           // single value at the bottom
      draw(ALL_ONES, ALL_ONES);               // single value at the top
      draw(ALL_ONES, '0);                     // empty range
      draw('0, 64'd1);
      draw(ALL_ONES - 1, ALL_ONES);
      draw('0, ALL_ONES - 1);
      draw(64'd1, ALL_ONES);
      draw(64'd5, 64'd9);
      draw('0, 64'd255);
      draw(64'h8000_0000_0000_0000, ALL_ONES);
      draw(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      draw(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_request(ActionRestart, ALL_ONES, '0);   // bounds of a restart are ignored
      draw('0, ALL_ONES);
      draw(64'd100, 64'd1000);
      send_request(ActionRestart, '0, '0);
      draw('0, 64'd2);
      draw(ALL_ONES >> 1, (ALL_ONES >> 1) + 1);
      draw('0, 64'h0000_0000_FFFF_FFFF);
      wait_idle();
      write_seed(ALL_ONES);
      send_request(ActionRestart, '0, '0);
      draw('0, ALL_ONES);
      draw(64'd3, 64'd7);

      // Random phases, each under its own seed. The first goes back to the
      // reset seed of zero; one phase runs with no gaps at all.
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p)
            0:       seed_value = '0;
            1:       seed_value = ALL_ONES;
            2:       seed_value = random_word();
            3:       seed_value = 64'd1;
            4:       seed_value = 64'h8000_0000_0000_0000;
            6:       seed_value = StartWordA;
            default: seed_value = random_word();
         endcase
         write_seed(seed_value);
         calm = (p == 5);
         // Usually restart under the new seed; sometimes carry the old
         // series on, so the register alone must not disturb the words.
         if ($urandom_range(0, 9) < 8) begin
            send_request(ActionRestart, random_word(), random_word());
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 3 && i == PHASE_ITEMS / 2) begin
               wait_idle();
            end
            random_request();
         end
      end
      calm = 1'b0;

      wait_idle();
      if (board.pending() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", board.pending()));
      end
      if (error_count == 0) begin
         $display("tb_small_fast_prng_ranged_draw_unit: clean");
      end else begin
         $display("tb_small_fast_prng_ranged_draw_unit: errors");
      end
      $finish;
   end

endmodule
